// ----- design/hamming13_secded_stream_decoder_core_macros.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef HAMMING13_SECDED_STREAM_DECODER_CORE_MACROS_SVH
`define HAMMING13_SECDED_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HM13_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define HM13_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hm13_pkg.sv -----
// Types and constants of the 13-bit Hamming SECDED stream decoder.
package hm13_pkg;

	localparam int unsigned CW_BITS  = 13;  // codeword length
	localparam int unsigned BYTE_W   = 8;   // input byte width
	localparam int unsigned HOLD_W   = 12;  // most bits ever held between bytes
	localparam int unsigned CNT_W    = 4;   // width of the held-bit count
	localparam int unsigned GATHER_W = HOLD_W + BYTE_W;
	localparam int unsigned NT_W     = 5;   // width of held bits plus one byte

	// Gearbox stage output
	typedef struct packed {
		logic [CW_BITS-1:0] cw;
		logic               have_cw;
		logic               last;
		logic               len_err;
	} gear_t;

	// Decoded codeword
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              corrected;
		logic              pfail;
	} dec_t;

endpackage

// ----- design/hamming13_secded_stream_decoder_core.sv -----
// Top level: byte-to-13-bit gearbox, codeword decode and output register.
// A result for the byte that completes its codeword (or ends the frame) passes the
// stage-1 and output registers before it is valid on the master side. Throughput: one
// byte per cycle unless the output stalls; the held-bit count updates in the accept cycle.
// Reset: arst_n clears the gearbox buffer, bit count and all valid flags.
`include "hamming13_secded_stream_decoder_core_macros.svh"

module hamming13_secded_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [8] was_corrected,
	                                    // [9] parity_fail, [10] length_error, rest 0
	output logic        m_axis_tlast    // last_out
);

	logic [hm13_pkg::HOLD_W-1:0]   buf_q;
	logic [hm13_pkg::CNT_W-1:0]    bit_count_q;

	logic [hm13_pkg::CNT_W-1:0]    cnt_clamp;
	logic [hm13_pkg::NT_W-1:0]     n_total;
	logic [hm13_pkg::NT_W-1:0]     n_left;
	logic [hm13_pkg::GATHER_W-1:0] gather;
	logic [hm13_pkg::GATHER_W-1:0] gather_sh;
	logic [hm13_pkg::GATHER_W-1:0] keep_mask;
	logic [hm13_pkg::HOLD_W-1:0]   buf_next;
	logic [2:0]                    shift_amt;
	hm13_pkg::gear_t               gear;

	logic                          in_acc;
	logic                          adv_s1;
	logic                          vld_s1;
	hm13_pkg::gear_t               gear_s1;
	hm13_pkg::dec_t                dec;

	logic                          vld_s2;
	logic [7:0]                    data_s2;
	logic                          corr_s2;
	logic                          pfail_s2;
	logic                          lerr_s2;
	logic                          last_s2;

	// Gearbox: append the byte, cut out a codeword when 13 bits are there
	always_comb begin
		cnt_clamp = (bit_count_q > 4'(hm13_pkg::HOLD_W)) ? 4'(hm13_pkg::HOLD_W) : bit_count_q;
		n_total   = {1'b0, cnt_clamp} + 5'(hm13_pkg::BYTE_W);
		gather    = {buf_q, s_axis_tdata};
		gear.have_cw = (n_total >= 5'(hm13_pkg::CW_BITS));
		shift_amt = 3'(n_total - 5'(hm13_pkg::CW_BITS));
		gather_sh = gather >> shift_amt;
		gear.cw   = gather_sh[hm13_pkg::CW_BITS-1:0];
		n_left    = gear.have_cw ? (n_total - 5'(hm13_pkg::CW_BITS)) : n_total;
		keep_mask = (20'd1 << n_left) - 20'd1;
		buf_next  = gather[hm13_pkg::HOLD_W-1:0] & keep_mask[hm13_pkg::HOLD_W-1:0];
		gear.last    = s_axis_tlast;
		gear.len_err = s_axis_tlast && (n_left != '0);
	end

	// Handshake: stage 1 moves on when the output register is free or drains
	assign adv_s1        = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Gearbox state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			bit_count_q <= '0;
		end else if (in_acc) begin
			if (s_axis_tlast) begin
				buf_q       <= '0;
				bit_count_q <= '0;
			end else begin
				buf_q       <= buf_next;
				bit_count_q <= n_left[hm13_pkg::CNT_W-1:0];
			end
		end
	end

	// Stage 1: only transactions that yield a result enter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= in_acc && (gear.have_cw || s_axis_tlast);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			gear_s1 <= gear;
		end
	end

	hm13_decode u_decode (
		.cw  (gear_s1.cw),
		.dec (dec)
	);

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_axis_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2  <= gear_s1.have_cw ? dec.data : '0;
			corr_s2  <= gear_s1.have_cw && dec.corrected;
			pfail_s2 <= gear_s1.have_cw && dec.pfail;
			lerr_s2  <= gear_s1.len_err;
			last_s2  <= gear_s1.last;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {5'd0, lerr_s2, pfail_s2, corr_s2, data_s2};
	assign m_axis_tlast  = last_s2;

	// Checks
	`HM13_ASSERT_NOW(a_count_range, 1'b1, bit_count_q <= 4'(hm13_pkg::HOLD_W),
		"held bit count above 12")
	`HM13_ASSERT_NOW(a_s1_reason, vld_s1 && !gear_s1.have_cw, gear_s1.last,
		"stage 1 holds a transaction with no codeword and no frame end")
	`HM13_ASSERT_NOW(a_lerr_last, m_axis_tvalid && m_axis_tdata[10], m_axis_tlast,
		"length error on a result that does not end the frame")
	`HM13_ASSERT_NEXT(a_frame_clear, s_axis_tvalid && s_axis_tready && s_axis_tlast,
		bit_count_q == '0, "gearbox not cleared after frame end")

endmodule

// ----- design/hm13_decode.sv -----
// Syndrome, single-bit correction and overall parity check of one codeword.
module hm13_decode (
	input  logic [hm13_pkg::CW_BITS-1:0] cw,
	output hm13_pkg::dec_t               dec
);

	logic [3:0]                   syn;
	logic [hm13_pkg::CW_BITS-1:0] fixed;
	logic                         par;

	always_comb begin
		// position p sits at bit CW_BITS-p; position 13 counts like any other
		syn = '0;
		for (int p = 1; p <= hm13_pkg::CW_BITS; p++) begin
			if (cw[hm13_pkg::CW_BITS-p]) begin
				syn = syn ^ 4'(p);
			end
		end

		// syndromes 1..12 flip one bit; 0 and 13..15 leave the word alone
		fixed         = cw;
		dec.corrected = 1'b0;
		if (syn >= 4'd1 && syn <= 4'd12) begin
			fixed[4'(hm13_pkg::CW_BITS) - syn] = ~cw[4'(hm13_pkg::CW_BITS) - syn];
			dec.corrected = 1'b1;
		end

		// data positions 3,5,6,7,9,10,11,12, position 3 as MSB
		dec.data = {fixed[10], fixed[8], fixed[7], fixed[6],
			fixed[4], fixed[3], fixed[2], fixed[1]};
		par       = ^dec.data;
		dec.pfail = fixed[0] ^ par;
	end

endmodule

// ----- verif/hamming13_secded_stream_decoder_core_tb.sv -----
// Testbench for the 13-bit Hamming SECDED stream decoder: self-checking, random stalls.
`timescale 1ns / 100ps

module hamming13_secded_stream_decoder_core_tb;

	// One decoded transaction on the master side
	typedef struct {
		logic [7:0] data;
		logic       corrected;
		logic       pfail;
		logic       len_err;
		logic       last;
	} decoded_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;

	// Predictor copy of the gearbox state
	logic [19:0] held_bits = '0;
	logic [3:0]  held_cnt = '0;

	decoded_t    expected_q[$];
	decoded_t    want;
	bit          frame_bits[$];   // bits of the frame being built, first bit at the front
	int unsigned bytes_sent = 0;
	int unsigned mismatches = 0;
	int unsigned hold_left = 0;   // long receiver hold-off, in cycles
	int unsigned gap_left = 0;    // current receiver idle burst
	bit          no_idle = 1'b0;

	hamming13_secded_stream_decoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Codeword position p (1..13) lives at bit 13-p; position 1 is sent first
	function automatic logic [12:0] pos_mask(input int unsigned p);
		return 13'd1 << (hm13_pkg::CW_BITS - p);
	endfunction

	function automatic logic [3:0] syndrome_of(input logic [12:0] cw);
		logic [3:0] s;
		s = '0;
		for (int p = 1; p <= hm13_pkg::CW_BITS; p++)
			if (cw[hm13_pkg::CW_BITS - p])
				s ^= 4'(p);
		return s;
	endfunction

	// Consume one byte; returns 1 when the byte causes a result
	function automatic bit decode_step(input logic [7:0] b, input logic fe,
			output decoded_t r);
		logic [19:0] acc;
		logic [12:0] cw;
		logic [3:0]  syn;
		int unsigned n;
		bit          got_cw;
		acc = {held_bits[11:0], b};
		n = (held_cnt > 12) ? 12 : held_cnt;
		n += 8;
		got_cw = 1'b0;
		r = '{default: 1'b0};
		if (n >= hm13_pkg::CW_BITS) begin
			got_cw = 1'b1;
			cw = 13'(acc >> (n - hm13_pkg::CW_BITS));
			n -= hm13_pkg::CW_BITS;
			acc &= (20'd1 << n) - 20'd1;
			syn = syndrome_of(cw);
			// single-bit repair only for syndromes that name a position below 13
			if (syn >= 1 && syn <= 12) begin
				cw ^= pos_mask(syn);
				r.corrected = 1'b1;
			end
			r.data = {cw[10], cw[8], cw[7], cw[6], cw[4], cw[3], cw[2], cw[1]};
			r.pfail = cw[0] ^ (^r.data);
		end
		if (fe) begin
			r.len_err = (n != 0);
			r.last = 1'b1;
			held_bits = '0;
			held_cnt = '0;
		end else begin
			held_bits = acc;
			held_cnt = 4'(n);
		end
		return got_cw || fe;
	endfunction

	// Clean codeword for a data byte, then the error pattern applied
	function automatic logic [12:0] build_codeword(input logic [7:0] d, input logic [12:0] err);
		logic [12:0] cw;
		logic [3:0]  s;
		cw = '0;
		{cw[10], cw[8], cw[7], cw[6], cw[4], cw[3], cw[2], cw[1]} = d;
		cw[0] = ^d;
		s = syndrome_of(cw);
		{cw[5], cw[9], cw[11], cw[12]} = s;
		return cw ^ err;
	endfunction

	// Half clean, the rest with single, double or triple bit errors
	function automatic logic [12:0] random_error();
		logic [12:0] m;
		int unsigned roll;
		int unsigned flips;
		m = '0;
		roll = $urandom_range(0, 99);
		flips = (roll < 50) ? 0 : (roll < 80) ? 1 : (roll < 95) ? 2 : 3;
		repeat (flips) m |= pos_mask($urandom_range(1, hm13_pkg::CW_BITS));
		return m;
	endfunction

	function automatic void add_codeword(input logic [7:0] d, input logic [12:0] err);
		logic [12:0] cw;
		cw = build_codeword(d, err);
		for (int j = hm13_pkg::CW_BITS - 1; j >= 0; j--)
			frame_bits = {frame_bits, cw[j]};
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// Offer one byte, wait for its transaction and record the prediction
	task automatic send_byte(input logic [7:0] b, input logic fe);
		decoded_t r;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= fe;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (decode_step(b, fe, r))
			expected_q = {expected_q, r};
		bytes_sent++;
		@(negedge clk);
	endtask

	// Pad the built bits to whole bytes with random filler and send as one frame
	task automatic send_frame();
		logic [7:0] b;
		while (frame_bits.size() % 8 != 0)
			frame_bits = {frame_bits, 1'($urandom)};
		while (frame_bits.size() != 0) begin
			for (int j = 7; j >= 0; j--)
				b[j] = frame_bits.pop_front();
			send_byte(b, frame_bits.size() == 0);
		end
	endtask

	// Random frame: mostly codeword sequences, some with stray bits, some pure noise
	task automatic send_random_frame();
		int unsigned roll;
		int unsigned n_cw;
		int unsigned n_bytes;
		roll = $urandom_range(0, 99);
		if (roll < 75) begin
			n_cw = ($urandom_range(0, 2) == 0) ? 8 : $urandom_range(1, 8);
			repeat (n_cw) add_codeword(8'($urandom), random_error());
			if (roll >= 60)
				repeat ($urandom_range(1, 12)) frame_bits = {frame_bits, 1'($urandom)};
			send_frame();
		end else begin
			n_bytes = $urandom_range(1, 20);
			for (int i = 1; i <= n_bytes; i++)
				send_byte(8'($urandom), i == n_bytes);
		end
	endtask

	// Stop offering and wait until every predicted transaction has arrived
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// Lone-byte frames, a short frame with leftover bits, and one exact
	// eight-codeword frame covering every syndrome class
	task automatic test_directed_cases();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		add_codeword(8'h00, 13'h0000);                // clean
		add_codeword(8'hFF, pos_mask(1));             // parity bit repaired
		add_codeword(8'hA5, pos_mask(12));            // data bit repaired
		add_codeword(8'h5A, pos_mask(13));            // overall parity hit: no flip, fail
		add_codeword(8'h3C, pos_mask(8));             // parity bit repaired
		add_codeword(8'hC3, pos_mask(7) | pos_mask(9));   // syndrome 14
		add_codeword(8'h0F, pos_mask(3) | pos_mask(12));  // syndrome 15
		add_codeword(8'hF0, pos_mask(1) | pos_mask(2) | pos_mask(3)); // syndrome 0, bad data
		send_frame();
		wait_idle();
	endtask

	task automatic test_random_frames();
		while (bytes_sent < 560)
			send_random_frame();
		wait_idle();
	endtask

	// Receiver holds off while full frames keep coming, so the input stalls
	task automatic test_output_backpressure();
		hold_left = 200;
		repeat (3) begin
			repeat (8) add_codeword(8'($urandom), random_error());
			send_frame();
		end
		wait_idle();
	endtask

	task automatic test_full_rate();
		no_idle = 1'b1;
		while (bytes_sent < 800)
			send_random_frame();
		wait_idle();
	endtask

	// Receiver side: long hold-off, random idle bursts, otherwise ready
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_axis_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(1, 16) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual tdata %h tlast %b",
					$time, m_axis_tdata, m_axis_tlast);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_field("data_byte", want.data, m_axis_tdata[7:0]);
				check_field("was_corrected", 8'(want.corrected), 8'(m_axis_tdata[8]));
				check_field("parity_fail", 8'(want.pfail), 8'(m_axis_tdata[9]));
				check_field("length_error", 8'(want.len_err), 8'(m_axis_tdata[10]));
				check_field("tdata pad bits", 8'h00, 8'(m_axis_tdata[15:11]));
				check_field("tlast", 8'(want.last), 8'(m_axis_tlast));
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_random_frames();
		test_output_backpressure();
		test_full_rate();
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
